/* src/ksat_pkg.sv */
// ----------------------------------------------------------------------------
// ksat_pkg
// Shared types and constants of the keyed sample aggregation table.
// ----------------------------------------------------------------------------
package ksat_pkg;

  localparam int SLOTS     = 1024;
  localparam int SLOT_AW   = $clog2(SLOTS);
  localparam int KEY_BYTES = 24;
  localparam int KEY_W     = KEY_BYTES * 8;
  localparam int KLEN_W    = $clog2(KEY_BYTES + 1);
  localparam int CFG_W     = 11;
  localparam int SMP_W     = 15;
  localparam int TOT_W     = 48;
  localparam int CNT_W     = 32;
  localparam int HASH_W    = 64;
  localparam int MOD_BITS  = 4;                  // remainder bits resolved per cycle
  localparam int MOD_STEPS = HASH_W / MOD_BITS;
  localparam int MSTEP_W   = $clog2(MOD_STEPS);
  localparam int IN_W      = 24;
  localparam int OUT_W     = 128;

  localparam logic [HASH_W-1:0] DJB_SEED  = 64'd5381;
  localparam logic [HASH_W-1:0] FNV_BASIS = 64'hcbf29ce484222325;
  localparam logic signed [SMP_W-1:0] SAMPLE_LIMIT = 15'sd9999;

  localparam logic [1:0] PROBE_DJB = 2'd0;
  localparam logic [1:0] PROBE_FNV = 2'd1;
  localparam logic [1:0] PROBE_SDB = 2'd2;

  typedef struct packed {
    logic [KEY_W-1:0]        key;
    logic [KLEN_W-1:0]       len;
    logic signed [SMP_W-1:0] lowest;
    logic signed [SMP_W-1:0] highest;
    logic signed [TOT_W-1:0] total;
    logic [CNT_W-1:0]        count;
  } slot_entry_t;

  typedef struct packed {
    logic       clear_wr;
    logic       byte_en;
    logic       mod_load;
    logic       mod_step;
    logic       mem_rd;
    logic       commit;
    logic       fail;
    logic [1:0] probe;
  } dp_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic mod_last;
    logic slot_ok;
    logic out_free;
  } dp_sts_t;

endpackage

/* src/keyed_sample_aggregation_table_core.sv */
// ----------------------------------------------------------------------------
// keyed_sample_aggregation_table_core
// Group-by engine: hashes streamed keys into a slot table and keeps the
// min, max, total and count of samples per key.
// ----------------------------------------------------------------------------
// Usage:
//  - Input beats carry one key byte each; in_tlast marks the last byte, whose
//    beat also carries the sample. Bytes past the 24th are ignored.
//  - Each record produces one output beat: slot, placed flag, probe used and
//    the slot's updated statistics, or all zeros when all three probes collide.
//  - Key bytes are taken while in_tready is high. After the last byte in_tready
//    drops while each probe runs load, remainder steps of 4 bits each, memory
//    read and compare, and through write-back, which waits for a free output
//    register. The result beat is registered at write-back.
//  - The result sits in an output register; key bytes of the next record keep
//    flowing while it waits, and only write-back holds while out_tready is low.
//  - After reset the slot memory is cleared, one entry a cycle, for all 1024
//    entries; in_tready stays low meanwhile. cfg writes are taken at any time
//    but only while idle is the effect defined.
// ----------------------------------------------------------------------------
module keyed_sample_aggregation_table_core import ksat_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [IN_W-1:0]  in_tdata,    // key_byte[7:0], sample[22:8], zero pad
  input  logic             in_tlast,    // key_end
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [OUT_W-1:0] out_tdata,   // slot[9:0], placed[10], probe_taken[12:11],
                                        // sample_count[44:13], lowest[59:45],
                                        // highest[74:60], running_total[122:75], pad
  input  logic             cfg_wr_en,
  input  logic [CFG_W-1:0] cfg_wr_data  // slots_in_use
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  ksat_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tlast  (in_tlast),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  ksat_datapath u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tdata    (in_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cmd         (cmd),
    .sts         (sts)
  );

endmodule

/* src/ksat_ctrl.sv */
// ----------------------------------------------------------------------------
// ksat_ctrl
// Controller: clearing pass, key intake, probe sequencing and write-back.
// ----------------------------------------------------------------------------
module ksat_ctrl import ksat_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_tvalid,
  input  logic    in_tlast,
  output logic    in_tready,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  typedef enum logic [6:0] {
    ST_CLEAR = 7'b0000001,
    ST_IDLE  = 7'b0000010,
    ST_LOAD  = 7'b0000100,
    ST_MOD   = 7'b0001000,
    ST_READ  = 7'b0010000,
    ST_CHECK = 7'b0100000,
    ST_WRITE = 7'b1000000
  } state_t;

  state_t     state_r, state_nxt;
  logic [1:0] probe_r, probe_nxt;
  logic       fail_r, fail_nxt;
  logic       take;

  assign in_tready = (state_r == ST_IDLE);
  assign take      = in_tvalid && in_tready;

  always_comb begin
    state_nxt = state_r;
    probe_nxt = probe_r;
    fail_nxt  = fail_r;
    cmd       = '0;
    cmd.probe = probe_r;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.clear_wr = 1'b1;
        if (sts.clear_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        cmd.byte_en = take;
        if (take && in_tlast) begin
          probe_nxt = PROBE_DJB;
          fail_nxt  = 1'b0;
          state_nxt = ST_LOAD;
        end
      end
      ST_LOAD: begin
        cmd.mod_load = 1'b1;
        state_nxt    = ST_MOD;
      end
      ST_MOD: begin
        cmd.mod_step = 1'b1;
        if (sts.mod_last) state_nxt = ST_READ;
      end
      ST_READ: begin
        cmd.mem_rd = 1'b1;
        state_nxt  = ST_CHECK;
      end
      ST_CHECK: begin
        priority if (sts.slot_ok) begin
          state_nxt = ST_WRITE;
        end else if (probe_r == PROBE_SDB) begin
          fail_nxt  = 1'b1;
          state_nxt = ST_WRITE;
        end else begin
          probe_nxt = probe_r + 2'd1;
          state_nxt = ST_LOAD;
        end
      end
      ST_WRITE: begin
        // hold until the output register is free
        if (sts.out_free) begin
          cmd.commit = !fail_r;
          cmd.fail   = fail_r;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      probe_r <= PROBE_DJB;
      fail_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      probe_r <= probe_nxt;
      fail_r  <= fail_nxt;
    end
  end

endmodule

/* src/ksat_datapath.sv */
// ----------------------------------------------------------------------------
// ksat_datapath
// Key buffer, running hashes, radix-16 remainder unit, slot memory and
// statistics update with the output register.
// ----------------------------------------------------------------------------
module ksat_datapath import ksat_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [IN_W-1:0]  in_tdata,
  input  logic             cfg_wr_en,
  input  logic [CFG_W-1:0] cfg_wr_data,
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [OUT_W-1:0] out_tdata,
  input  dp_cmd_t          cmd,
  output dp_sts_t          sts
);

  logic [CFG_W-1:0]        slots_cfg_r;
  logic [KEY_W-1:0]        key_buf_r;
  logic [KLEN_W-1:0]       key_len_r;
  logic [HASH_W-1:0]       djb_r, fnv_r, sdb_r;
  logic [HASH_W-1:0]       djb_nxt, fnv_nxt, sdb_nxt, fnv_x;
  logic [KEY_W-1:0]        key_buf_nxt;
  logic signed [SMP_W-1:0] sample_raw, sample_r;
  logic [7:0]              kb;
  logic [SLOT_AW-1:0]      clr_cnt_r;
  logic [CFG_W-1:0]        n_eff;
  logic [SLOT_AW-1:0]      m_div;
  logic [HASH_W-1:0]       sh_r;
  logic [SLOT_AW-1:0]      rem_r, rem_nxt, slot_idx;
  logic [SLOT_AW:0]        rr;
  logic [MSTEP_W-1:0]      mstep_r;
  slot_entry_t             mem [SLOTS];
  slot_entry_t             rd_r, wr_data;
  logic                    we;
  logic [SLOT_AW-1:0]      waddr;
  logic signed [SMP_W-1:0] new_lo, new_hi;
  logic signed [TOT_W:0]   sum;
  logic signed [TOT_W-1:0] new_tot;
  logic [CNT_W-1:0]        new_cnt;
  logic                    out_valid_r;
  logic [OUT_W-1:0]        out_data_r;

  assign kb         = in_tdata[7:0];
  assign sample_raw = in_tdata[22:8];

  // effective slot count and divisor
  always_comb begin
    n_eff = slots_cfg_r;
    if (n_eff < CFG_W'(4)) n_eff = CFG_W'(4);
    if (n_eff > CFG_W'(SLOTS)) n_eff = CFG_W'(SLOTS);
  end
  assign m_div = SLOT_AW'(n_eff - CFG_W'(1));

  // hash updates; FNV prime is 2^40 + 0x1b3
  always_comb begin
    fnv_x   = fnv_r ^ {56'd0, kb};
    djb_nxt = (djb_r << 5) + djb_r + {56'd0, kb};
    fnv_nxt = (fnv_x << 40) + fnv_x + (fnv_x << 1) + (fnv_x << 4) + (fnv_x << 5)
            + (fnv_x << 7) + (fnv_x << 8);
    sdb_nxt = {56'd0, kb} + (sdb_r << 6) + (sdb_r << 16) - sdb_r;
    key_buf_nxt = key_buf_r;
    for (int i = 0; i < KEY_BYTES; i++) begin
      if (key_len_r == KLEN_W'(i)) key_buf_nxt[i*8 +: 8] = kb;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slots_cfg_r <= CFG_W'(SLOTS);
      key_buf_r   <= '0;
      key_len_r   <= '0;
      djb_r       <= DJB_SEED;
      fnv_r       <= FNV_BASIS;
      sdb_r       <= '0;
      clr_cnt_r   <= '0;
    end else begin
      if (cfg_wr_en) slots_cfg_r <= cfg_wr_data;
      if (cmd.clear_wr) clr_cnt_r <= clr_cnt_r + SLOT_AW'(1);
      if (cmd.commit || cmd.fail) begin
        key_buf_r <= '0;
        key_len_r <= '0;
        djb_r     <= DJB_SEED;
        fnv_r     <= FNV_BASIS;
        sdb_r     <= '0;
      end else if (cmd.byte_en && key_len_r < KLEN_W'(KEY_BYTES)) begin
        key_buf_r <= key_buf_nxt;
        key_len_r <= key_len_r + KLEN_W'(1);
        djb_r     <= djb_nxt;
        fnv_r     <= fnv_nxt;
        sdb_r     <= sdb_nxt;
      end
    end
  end

  // clamp and hold the sample of the last key byte
  always_ff @(posedge clk) begin
    if (cmd.byte_en) begin
      if (sample_raw > SAMPLE_LIMIT) sample_r <= SAMPLE_LIMIT;
      else if (sample_raw < -SAMPLE_LIMIT) sample_r <= -SAMPLE_LIMIT;
      else sample_r <= sample_raw;
    end
  end

  // remainder unit: four restoring steps per cycle, MSB first
  always_comb begin
    rr = {1'b0, rem_r};
    for (int i = 0; i < MOD_BITS; i++) begin
      rr = {rr[SLOT_AW-1:0], sh_r[HASH_W-1-i]};
      if (rr >= {1'b0, m_div}) rr = rr - {1'b0, m_div};
    end
    rem_nxt = rr[SLOT_AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.mod_load) begin
      unique case (cmd.probe)
        PROBE_DJB: sh_r <= djb_r;
        PROBE_FNV: sh_r <= fnv_r;
        default:   sh_r <= sdb_r;
      endcase
      rem_r   <= '0;
      mstep_r <= '0;
    end else if (cmd.mod_step) begin
      sh_r    <= sh_r << MOD_BITS;
      rem_r   <= rem_nxt;
      mstep_r <= mstep_r + MSTEP_W'(1);
    end
  end

  assign slot_idx = rem_r + SLOT_AW'(1);

  // statistics update
  always_comb begin
    if (rd_r.count == '0) begin
      new_lo = sample_r;
      new_hi = sample_r;
      sum    = (TOT_W+1)'(sample_r);
    end else begin
      new_lo = (sample_r < rd_r.lowest)  ? sample_r : rd_r.lowest;
      new_hi = (sample_r > rd_r.highest) ? sample_r : rd_r.highest;
      sum    = (TOT_W+1)'(rd_r.total) + (TOT_W+1)'(sample_r);
    end
    if (sum[TOT_W] != sum[TOT_W-1]) new_tot = sum[TOT_W] ? {1'b1, {(TOT_W-1){1'b0}}}
                                                         : {1'b0, {(TOT_W-1){1'b1}}};
    else new_tot = sum[TOT_W-1:0];
    new_cnt = (rd_r.count == '1) ? rd_r.count : rd_r.count + CNT_W'(1);
  end

  always_comb begin
    we    = cmd.clear_wr || cmd.commit;
    waddr = cmd.clear_wr ? clr_cnt_r : slot_idx;
    if (cmd.clear_wr) begin
      wr_data = '0;
    end else begin
      wr_data.key     = key_buf_r;
      wr_data.len     = key_len_r;
      wr_data.lowest  = new_lo;
      wr_data.highest = new_hi;
      wr_data.total   = new_tot;
      wr_data.count   = new_cnt;
    end
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wr_data;
    if (cmd.mem_rd) rd_r <= mem[slot_idx];
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit || cmd.fail) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_data_r <= {5'd0, new_tot, new_hi, new_lo, new_cnt, cmd.probe, 1'b1, slot_idx};
    end else if (cmd.fail) begin
      out_data_r <= '0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign sts.clear_last = (clr_cnt_r == SLOT_AW'(SLOTS - 1));
  assign sts.mod_last   = (mstep_r == MSTEP_W'(MOD_STEPS - 1));
  assign sts.slot_ok    = (rd_r.len == '0)
                       || (rd_r.len == key_len_r && rd_r.key == key_buf_r);
  assign sts.out_free   = !out_valid_r || out_tready;

endmodule
